// File: rtl/core/ucrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucrr_pkg: shared types, codes and descriptor tables
// Request and event codes, command beat layout between the front and back
// ends, descriptor tables and the byte lookup used by the back end.
// ----------------------------------------------------------------------------
package ucrr_pkg;

    localparam int MAX_PACKET_BYTES = 64;
    localparam int LEN_W            = $clog2(MAX_PACKET_BYTES + 1);
    localparam int IDX_W            = $clog2(MAX_PACKET_BYTES);

    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    localparam logic [15:0] VENDOR_ID_RESET  = 16'h1209;
    localparam logic [15:0] PRODUCT_ID_RESET = 16'h0001;
    localparam logic        REG_VENDOR_ID    = 1'b0;
    localparam logic        REG_PRODUCT_ID   = 1'b1;

    localparam logic [7:0] RQ_GET_STATUS        = 8'd0;
    localparam logic [7:0] RQ_SET_ADDRESS       = 8'd5;
    localparam logic [7:0] RQ_GET_DESCRIPTOR    = 8'd6;
    localparam logic [7:0] RQ_GET_CONFIGURATION = 8'd8;
    localparam logic [7:0] RQ_SET_CONFIGURATION = 8'd9;
    localparam logic [7:0] RQ_SET_INTERFACE     = 8'd11;

    localparam logic [7:0] DT_DEVICE = 8'h01;
    localparam logic [7:0] DT_CONFIG = 8'h02;
    localparam logic [7:0] DT_STRING = 8'h03;
    localparam logic [7:0] DT_REPORT = 8'h22;

    localparam logic [7:0] STR_LANG    = 8'd0;
    localparam logic [7:0] STR_MFR     = 8'd1;
    localparam logic [7:0] STR_PRODUCT = 8'd2;

    localparam int DEV_LEN    = 18;
    localparam int CFG_TOTAL  = 9 + 9 + 9 + 7;
    localparam int STR0_LEN   = 4;
    localparam int STR1_LEN   = 12;
    localparam int STR2_LEN   = 26;
    localparam int REPORT_LEN = 45;
    localparam int STATUS_LEN = 2;

    localparam logic [7:0] DEV_MPS_IDX  = 8'd7;
    localparam logic [7:0] DEV_VID_LO   = 8'd8;
    localparam logic [7:0] DEV_VID_HI   = 8'd9;
    localparam logic [7:0] DEV_PID_LO   = 8'd10;
    localparam logic [7:0] DEV_PID_HI   = 8'd11;

    localparam logic [7:0] DEV_ROM [DEV_LEN] = '{
        8'd18, 8'd1, 8'h00, 8'h02, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'h00, 8'h01, 8'd1, 8'd2, 8'd0, 8'd1
    };

    localparam logic [7:0] REPORT_ROM [REPORT_LEN] = '{
        8'h05, 8'h01, 8'h09, 8'h06, 8'hA1, 8'h01, 8'h05, 8'h07, 8'h19, 8'hE0,
        8'h29, 8'hE7, 8'h15, 8'h00, 8'h25, 8'h01, 8'h75, 8'h01, 8'h95, 8'h08,
        8'h81, 8'h02, 8'h95, 8'h01, 8'h75, 8'h08, 8'h81, 8'h01, 8'h95, 8'h06,
        8'h75, 8'h08, 8'h15, 8'h00, 8'h25, 8'h65, 8'h05, 8'h07, 8'h19, 8'h00,
        8'h29, 8'h65, 8'h81, 8'h00, 8'hC0
    };

    localparam logic [7:0] CFG_ROM [CFG_TOTAL] = '{
        8'd9, 8'd2, 8'(CFG_TOTAL), 8'd0, 8'd1, 8'd1, 8'd0, 8'h80, 8'd50,
        8'd9, 8'd4, 8'd0, 8'd0, 8'd1, 8'd3, 8'd1, 8'd1, 8'd0,
        8'd9, 8'h21, 8'h11, 8'h01, 8'd0, 8'd1, 8'h22, 8'd45, 8'd0,
        8'd7, 8'd5, 8'h81, 8'h03, 8'd8, 8'd0, 8'd10
    };

    localparam logic [7:0] STR0_ROM [STR0_LEN] = '{8'd4, 8'd3, 8'h09, 8'h04};

    localparam logic [7:0] STR1_ROM [STR1_LEN] = '{
        8'd12, 8'd3, 8'h48, 8'd0, 8'h61, 8'd0, 8'h6B, 8'd0, 8'h61, 8'd0, 8'h6E, 8'd0
    };

    localparam logic [7:0] STR2_ROM [STR2_LEN] = '{
        8'd26, 8'd3, 8'h4D, 8'd0, 8'h65, 8'd0, 8'h64, 8'd0, 8'h69, 8'd0,
        8'h61, 8'd0, 8'h20, 8'd0, 8'h50, 8'd0, 8'h61, 8'd0, 8'h64, 8'd0,
        8'h20, 8'd0, 8'h76, 8'd0, 8'h31, 8'd0
    };

    typedef enum logic [1:0] {
        EV_SETUP     = 2'd0,
        EV_IN_DONE   = 2'd1,
        EV_BUS_RESET = 2'd2,
        EV_UNUSED    = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_ZLP   = 2'd1,
        KIND_STALL = 2'd2,
        KIND_EVENT = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        SRC_DEV,
        SRC_CFG,
        SRC_STR0,
        SRC_STR1,
        SRC_STR2,
        SRC_REPORT,
        SRC_ZERO,
        SRC_CONF_VAL
    } src_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_SET_ADDR,
        ACT_SET_CFG,
        ACT_IN_DONE,
        ACT_BUS_RESET
    } act_t;

    typedef struct packed {
        logic             is_single;
        kind_t            kind;
        src_t             src;
        logic [LEN_W-1:0] len;
        act_t             act;
        logic [7:0]       arg;
    } cmd_t;

    function automatic logic [LEN_W-1:0] cap_len(input logic [15:0] n);
        logic [LEN_W-1:0] r;
        if (n > 16'(MAX_PACKET_BYTES))
            r = LEN_W'(MAX_PACKET_BYTES);
        else
            r = n[LEN_W-1:0];
        return r;
    endfunction

    function automatic logic [7:0] rom_byte(
        input src_t             src,
        input logic [IDX_W-1:0] idx,
        input logic [15:0]      vid,
        input logic [15:0]      pid,
        input logic [7:0]       conf
    );
        logic [7:0] i;
        logic [7:0] b;
        i = 8'(idx);
        b = 8'd0;
        case (src)
            SRC_DEV:
            begin
                if (i < 8'(DEV_LEN))
                    b = DEV_ROM[i[4:0]];
                if (i == DEV_MPS_IDX)
                    b = 8'(MAX_PACKET_BYTES);
                else if (i == DEV_VID_LO)
                    b = vid[7:0];
                else if (i == DEV_VID_HI)
                    b = vid[15:8];
                else if (i == DEV_PID_LO)
                    b = pid[7:0];
                else if (i == DEV_PID_HI)
                    b = pid[15:8];
            end
            SRC_CFG:
            begin
                if (i < 8'(CFG_TOTAL))
                    b = CFG_ROM[i[5:0]];
            end
            SRC_STR0:
            begin
                if (i < 8'(STR0_LEN))
                    b = STR0_ROM[i[1:0]];
            end
            SRC_STR1:
            begin
                if (i < 8'(STR1_LEN))
                    b = STR1_ROM[i[3:0]];
            end
            SRC_STR2:
            begin
                if (i < 8'(STR2_LEN))
                    b = STR2_ROM[i[4:0]];
            end
            SRC_REPORT:
            begin
                if (i < 8'(REPORT_LEN))
                    b = REPORT_ROM[i[5:0]];
            end
            SRC_CONF_VAL:
            begin
                b = conf;
            end
            default:
            begin
                b = 8'd0;
            end
        endcase
        return b;
    endfunction

endpackage

// File: rtl/core/usb_control_request_responder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_control_request_responder: control endpoint standard request handler
// Answers setup packets, IN-complete events and bus resets with result beats.
// ----------------------------------------------------------------------------
// Each event pushed in is decoded in the same cycle into a command and held
// in a two-entry command queue; the reply sequencer then takes a command,
// applies its address or configuration update, and emits one result beat
// per cycle after that while pop keeps the output register free. It takes no
// new command until the last beat of the reply has been emitted. A zero-length
// packet, stall or event acknowledge is a single beat, and the 45-byte report
// descriptor is the longest reply. Every result beat carries the address and
// configuration in force after its event was handled. vendor_id (index 0)
// and product_id (index 1) are written through the cfg port, which is always
// ready, and must only be written while no reply is outstanding.
// ----------------------------------------------------------------------------
module usb_control_request_responder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  req_type,
    input  logic [7:0]  request_code,
    input  logic [15:0] request_value,
    input  logic [15:0] request_length,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [7:0]  data_byte,
    output logic        last,
    output logic [6:0]  device_address,
    output logic [7:0]  active_configuration,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import ucrr_pkg::*;

    logic        fifo_full;
    logic        fifo_empty;
    logic        cmd_push;
    logic        cmd_pop;
    cmd_t        front_cmd;
    cmd_t        back_cmd;
    logic [15:0] vendor_reg;
    logic [15:0] product_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vendor_reg  <= VENDOR_ID_RESET;
            product_reg <= PRODUCT_ID_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_VENDOR_ID)
                vendor_reg <= cfg_data;
            else if (cfg_index == REG_PRODUCT_ID)
                product_reg <= cfg_data;
        end
    end

    ucrr_front u_front (
        .push           (push),
        .full           (full),
        .req_type       (req_type),
        .request_code   (request_code),
        .request_value  (request_value),
        .request_length (request_length),
        .fifo_full      (fifo_full),
        .cmd_push       (cmd_push),
        .cmd            (front_cmd)
    );

    ucrr_cmd_fifo u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (front_cmd),
        .full    (fifo_full),
        .rd_en   (cmd_pop),
        .rd_data (back_cmd),
        .empty   (fifo_empty)
    );

    ucrr_back u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd_valid            (!fifo_empty),
        .cmd                  (back_cmd),
        .cmd_pop              (cmd_pop),
        .vendor_id            (vendor_reg),
        .product_id           (product_reg),
        .empty                (empty),
        .pop                  (pop),
        .kind                 (kind),
        .data_byte            (data_byte),
        .last                 (last),
        .device_address       (device_address),
        .active_configuration (active_configuration)
    );

endmodule

// File: rtl/core/ucrr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucrr_front: event decoder
// Classifies each accepted event into a command beat for the back end:
// reply source and length, single-result kind and state action.
// ----------------------------------------------------------------------------
module ucrr_front (
    input  logic              push,
    output logic              full,
    input  logic [1:0]        req_type,
    input  logic [7:0]        request_code,
    input  logic [15:0]       request_value,
    input  logic [15:0]       request_length,
    input  logic              fifo_full,
    output logic              cmd_push,
    output ucrr_pkg::cmd_t    cmd
);
    import ucrr_pkg::*;

    logic [LEN_W-1:0] dlen;
    logic             is_stream;
    logic [15:0]      cfg_len;

    assign full     = fifo_full;
    assign cmd_push = push && !fifo_full && (event_t'(req_type) != EV_UNUSED);
    assign cfg_len  = (request_length < 16'(CFG_TOTAL)) ? request_length : 16'(CFG_TOTAL);

    always_comb
    begin
        cmd.is_single = 1'b1;
        cmd.kind      = KIND_STALL;
        cmd.src       = SRC_ZERO;
        cmd.len       = LEN_W'(1);
        cmd.act       = ACT_NONE;
        cmd.arg       = request_value[7:0];
        dlen          = '0;
        is_stream     = 1'b0;

        case (event_t'(req_type))
            EV_IN_DONE:
            begin
                cmd.kind = KIND_EVENT;
                cmd.act  = ACT_IN_DONE;
            end
            EV_BUS_RESET:
            begin
                cmd.kind = KIND_EVENT;
                cmd.act  = ACT_BUS_RESET;
            end
            EV_SETUP:
            begin
                case (request_code)
                    RQ_SET_ADDRESS:
                    begin
                        cmd.kind = KIND_ZLP;
                        cmd.act  = ACT_SET_ADDR;
                    end
                    RQ_SET_CONFIGURATION:
                    begin
                        cmd.kind = KIND_ZLP;
                        cmd.act  = ACT_SET_CFG;
                    end
                    RQ_SET_INTERFACE:
                    begin
                        cmd.kind = KIND_ZLP;
                    end
                    RQ_GET_CONFIGURATION:
                    begin
                        cmd.is_single = 1'b0;
                        cmd.src       = SRC_CONF_VAL;
                        cmd.len       = LEN_W'(1);
                    end
                    RQ_GET_STATUS:
                    begin
                        cmd.is_single = 1'b0;
                        cmd.src       = SRC_ZERO;
                        cmd.len       = LEN_W'(STATUS_LEN);
                    end
                    RQ_GET_DESCRIPTOR:
                    begin
                        case (request_value[15:8])
                            DT_DEVICE:
                            begin
                                is_stream = 1'b1;
                                cmd.src   = SRC_DEV;
                                dlen      = cap_len(16'(DEV_LEN));
                            end
                            DT_CONFIG:
                            begin
                                is_stream = 1'b1;
                                cmd.src   = SRC_CFG;
                                dlen      = cap_len(cfg_len);
                            end
                            DT_STRING:
                            begin
                                case (request_value[7:0])
                                    STR_LANG:
                                    begin
                                        is_stream = 1'b1;
                                        cmd.src   = SRC_STR0;
                                        dlen      = cap_len(16'(STR0_LEN));
                                    end
                                    STR_MFR:
                                    begin
                                        is_stream = 1'b1;
                                        cmd.src   = SRC_STR1;
                                        dlen      = cap_len(16'(STR1_LEN));
                                    end
                                    STR_PRODUCT:
                                    begin
                                        is_stream = 1'b1;
                                        cmd.src   = SRC_STR2;
                                        dlen      = cap_len(16'(STR2_LEN));
                                    end
                                    default:
                                    begin
                                        cmd.kind = KIND_STALL;
                                    end
                                endcase
                            end
                            DT_REPORT:
                            begin
                                is_stream = 1'b1;
                                cmd.src   = SRC_REPORT;
                                dlen      = cap_len(16'(REPORT_LEN));
                            end
                            default:
                            begin
                                cmd.kind = KIND_STALL;
                            end
                        endcase

                        // empty reply goes out as a zero-length packet
                        if (is_stream)
                        begin
                            if (dlen == '0)
                            begin
                                cmd.kind = KIND_ZLP;
                            end
                            else
                            begin
                                cmd.is_single = 1'b0;
                                cmd.len       = dlen;
                            end
                        end
                    end
                    default:
                    begin
                        cmd.kind = KIND_STALL;
                    end
                endcase
            end
            default:
            begin
                cmd.kind = KIND_STALL;
            end
        endcase
    end

endmodule

// File: rtl/core/ucrr_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucrr_cmd_fifo: command queue
// Short queue of decoded command beats between the front and back ends.
// ----------------------------------------------------------------------------
module ucrr_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  ucrr_pkg::cmd_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output ucrr_pkg::cmd_t rd_data,
    output logic           empty
);
    import ucrr_pkg::*;

    cmd_t                 slot_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_CNT_W-1:0] count_reg;
    logic [CMD_CNT_W-1:0] count_next;
    logic                 do_wr;
    logic                 do_rd;

    function automatic logic [CMD_PTR_W-1:0] ptr_inc(input logic [CMD_PTR_W-1:0] p);
        logic [CMD_PTR_W-1:0] r;
        if (p == CMD_PTR_W'(CMD_DEPTH - 1))
            r = '0;
        else
            r = p + CMD_PTR_W'(1);
        return r;
    endfunction

    assign full    = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + CMD_CNT_W'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - CMD_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_rd)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// File: rtl/core/ucrr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucrr_back: reply sequencer
// Takes command beats, applies address and configuration updates, and emits
// the result beats one per cycle into the output register while it is free or popped.
// ----------------------------------------------------------------------------
module ucrr_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  ucrr_pkg::cmd_t cmd,
    output logic           cmd_pop,
    input  logic [15:0]    vendor_id,
    input  logic [15:0]    product_id,
    output logic           empty,
    input  logic           pop,
    output logic [1:0]     kind,
    output logic [7:0]     data_byte,
    output logic           last,
    output logic [6:0]     device_address,
    output logic [7:0]     active_configuration
);
    import ucrr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    cmd_t             cur_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [6:0]       addr_reg;
    logic [6:0]       pend_reg;
    logic             wait_reg;
    logic [7:0]       conf_reg;

    logic             out_valid_reg;
    kind_t            out_kind_reg;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;
    logic [6:0]       out_addr_reg;
    logic [7:0]       out_conf_reg;

    logic             out_free;
    logic             emit;
    logic             is_end;
    kind_t            emit_kind;
    logic [7:0]       emit_byte;

    assign out_free = !out_valid_reg || pop;
    assign cmd_pop  = (state_reg == S_IDLE) && cmd_valid;
    assign emit     = (state_reg == S_RUN) && out_free;
    assign is_end   = cur_reg.is_single ||
                      ((LEN_W'(idx_reg) + LEN_W'(1)) == cur_reg.len);

    assign emit_kind = cur_reg.is_single ? cur_reg.kind : KIND_DATA;
    assign emit_byte = cur_reg.is_single ? 8'd0 :
                       rom_byte(cur_reg.src, idx_reg, vendor_id, product_id, conf_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                    state_next = S_RUN;
            end
            S_RUN:
            begin
                if (emit && is_end)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            addr_reg      <= '0;
            pend_reg      <= '0;
            wait_reg      <= 1'b0;
            conf_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // state updates land before the first beat of the item
            if (cmd_pop)
            begin
                idx_reg <= '0;
                case (cmd.act)
                    ACT_SET_ADDR:
                    begin
                        pend_reg <= cmd.arg[6:0];
                        wait_reg <= 1'b1;
                    end
                    ACT_SET_CFG:
                    begin
                        conf_reg <= cmd.arg;
                    end
                    ACT_IN_DONE:
                    begin
                        if (wait_reg)
                        begin
                            addr_reg <= pend_reg;
                            wait_reg <= 1'b0;
                        end
                    end
                    ACT_BUS_RESET:
                    begin
                        addr_reg <= '0;
                        wait_reg <= 1'b0;
                        conf_reg <= '0;
                    end
                    default:
                    begin
                        wait_reg <= wait_reg;
                    end
                endcase
            end
            else if (emit && !is_end)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end

            if (emit)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
            cur_reg <= cmd;
        if (emit)
        begin
            out_kind_reg <= emit_kind;
            out_byte_reg <= emit_byte;
            out_last_reg <= is_end;
            out_addr_reg <= addr_reg;
            out_conf_reg <= conf_reg;
        end
    end

    assign empty                = !out_valid_reg;
    assign kind                 = out_kind_reg;
    assign data_byte            = out_byte_reg;
    assign last                 = out_last_reg;
    assign device_address       = out_addr_reg;
    assign active_configuration = out_conf_reg;

endmodule
